@@ hdl/atiu_pkg.sv @@
// Shared types, command codes and defaults for the array tree index unit.
package atiu_pkg;

	localparam int FIELD_W       = 16;
	localparam int CMD_W         = 4;
	localparam int NODE_BITS_DEF = 16;
	localparam int PATH_CAP_DEF  = 16;
	localparam int MAX_RESULTS   = 16;

	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [CMD_W-1:0]   cmd_t;

	localparam field_t N_LEAVES_RST = 16'd1;
	localparam field_t FIELD_MAX    = 16'hFFFF;

	localparam cmd_t CMD_LEVEL     = 4'd0;
	localparam cmd_t CMD_LEFT      = 4'd1;
	localparam cmd_t CMD_RIGHT     = 4'd2;
	localparam cmd_t CMD_PARENT    = 4'd3;
	localparam cmd_t CMD_SIBLING   = 4'd4;
	localparam cmd_t CMD_ROOT      = 4'd5;
	localparam cmd_t CMD_DPATH     = 4'd6;
	localparam cmd_t CMD_COPATH    = 4'd7;
	localparam cmd_t CMD_IN_SUBTREE = 4'd8;
	localparam cmd_t CMD_ANCESTOR  = 4'd9;
	localparam cmd_t CMD_LEAF2NODE = 4'd10;
	localparam cmd_t CMD_NODE2LEAF = 4'd11;
	localparam cmd_t CMD_IS_LEAF   = 4'd12;
	localparam cmd_t CMD_WIDTH     = 4'd13;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic single;
		logic step;
	} dp_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic path_cmd;
		logic step_last;
	} dp_sts_t;

endpackage

@@ hdl/atiu_ctrl.sv @@
// Controller state machine: sequences single-result and path commands.
module atiu_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  atiu_pkg::dp_sts_t sts,
	output atiu_pkg::dp_ctl_t ctl,
	output logic             busy
);
	import atiu_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SINGLE = 2'd1;
	localparam logic [1:0] ST_PATH   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load  = 1'b1;
					state_nxt = sts.path_cmd ? ST_PATH : ST_SINGLE;
				end
			end
			ST_SINGLE: begin
				ctl.single = 1'b1;
				state_nxt  = ST_IDLE;
			end
			ST_PATH: begin
				ctl.step = 1'b1;
				if (sts.step_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

@@ hdl/atiu_dp.sv @@
// Datapath: tree index arithmetic, path walker and registered result.
module atiu_dp #(
	parameter int NB  = atiu_pkg::NODE_BITS_DEF,
	parameter int CAP_IN = atiu_pkg::PATH_CAP_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  atiu_pkg::dp_ctl_t ctl,
	output atiu_pkg::dp_sts_t sts,
	input  atiu_pkg::cmd_t    command,
	input  atiu_pkg::field_t  node_a,
	input  atiu_pkg::field_t  node_b,
	input  logic              cfg_wr_en,
	input  atiu_pkg::field_t  cfg_wr_data,
	output logic              strobe,
	output atiu_pkg::field_t  value,
	output logic              flag,
	output logic              empty_res,
	output logic              last
);
	import atiu_pkg::*;

	localparam int LW  = $clog2(NB + 1);
	localparam int CAP = (CAP_IN < MAX_RESULTS) ? CAP_IN : MAX_RESULTS;
	localparam int CW  = $clog2(CAP + 1);
	localparam int WW  = (NB + 1 > FIELD_W + 1) ? NB + 1 : FIELD_W + 1;

	typedef logic [NB-1:0] node_t;
	typedef logic [NB:0]   wn_t;
	typedef logic [NB+1:0] ct_t;
	typedef logic [LW-1:0] lvl_t;
	typedef logic [LW:0]   lvlx_t;
	typedef logic [CW-1:0] cnt_t;
	typedef logic [CW:0]   cntx_t;
	typedef logic [WW-1:0] wx_t;

	// count of trailing ones
	function automatic lvl_t lvl(input node_t x);
		lvl_t k;
		logic stop;
		k    = '0;
		stop = 1'b0;
		for (int i = 0; i < NB; i++) begin
			if (!stop) begin
				if (x[i]) begin
					k = lvl_t'(i + 1);
				end else begin
					stop = 1'b1;
				end
			end
		end
		return k;
	endfunction

	function automatic node_t lchild(input node_t x);
		lvl_t k;
		k = lvl(x);
		if (k == '0) begin
			return x;
		end
		return x ^ (node_t'(1) << (k - lvl_t'(1)));
	endfunction

	function automatic node_t rchild(input node_t x);
		lvl_t k;
		k = lvl(x);
		if (k == '0) begin
			return x;
		end
		return x ^ (node_t'(3) << (k - lvl_t'(1)));
	endfunction

	// parent in a full tree; the all-ones node is its own parent
	function automatic node_t up(input node_t x);
		lvl_t  k;
		lvlx_t kp1;
		node_t bb;
		k   = lvl(x);
		kp1 = {1'b0, k} + lvlx_t'(1);
		bb  = node_t'((x >> kp1) & node_t'(1));
		return (x | (node_t'(1) << k)) ^ (bb << kp1);
	endfunction

	function automatic node_t sib(input node_t x);
		node_t p;
		p = up(x);
		return (x < p) ? rchild(p) : lchild(p);
	endfunction

	function automatic logic contains(input node_t anc, input node_t desc);
		lvl_t k;
		ct_t  span;
		ct_t  lo;
		ct_t  hi;
		k    = lvl(anc);
		span = ct_t'(1) << k;
		lo   = ct_t'(anc) + ct_t'(1) - span;
		hi   = ct_t'(anc) - ct_t'(1) + span;
		if (k == '0) begin
			return anc == desc;
		end
		return (ct_t'(desc) >= lo) && (ct_t'(desc) <= hi);
	endfunction

	function automatic node_t meet(input node_t x, input node_t y);
		lvlx_t la;
		lvlx_t lb;
		node_t d;
		node_t res;
		lvl_t  k;
		la  = {1'b0, lvl(x)} + lvlx_t'(1);
		lb  = {1'b0, lvl(y)} + lvlx_t'(1);
		d   = x ^ y;
		k   = '0;
		res = '0;
		if ((la <= lb) && ((x >> lb) == (y >> lb))) begin
			return y;
		end
		if ((lb <= la) && ((x >> la) == (y >> la))) begin
			return x;
		end
		// k is the bit length of the difference
		for (int i = 0; i < NB; i++) begin
			if (d[i]) begin
				k = lvl_t'(i + 1);
			end
		end
		for (int i = 0; i < NB; i++) begin
			if (i >= int'(k)) begin
				res[i] = x[i];
			end else begin
				res[i] = ((i + 1) < int'(k));
			end
		end
		return res;
	endfunction

	field_t n_leaves_q;
	cmd_t   cmd_q;
	node_t  a_q;
	node_t  b_q;
	node_t  cur_q;
	cnt_t   cnt_q;

	logic   strobe_q;
	field_t value_q;
	logic   flag_q;
	logic   empty_q;
	logic   last_q;

	node_t  n_c;
	wn_t    w_c;
	wx_t    wx_c;
	node_t  root_c;
	node_t  nxt_c;
	node_t  ent_c;
	logic   at_root_c;
	logic   step_last_c;
	field_t sval_c;
	logic   sflag_c;

	// node width and root from the leaf count
	always_comb begin
		n_c    = node_t'(n_leaves_q);
		w_c    = (n_c == '0) ? '0 : {n_c - node_t'(1), 1'b1};
		wx_c   = wx_t'(w_c);
		root_c = '0;
		for (int i = 0; i < NB; i++) begin
			root_c[i] = ((w_c >> (i + 1)) != '0);
		end
	end

	// one path entry per step
	always_comb begin
		nxt_c       = up(cur_q);
		ent_c       = (cmd_q == CMD_COPATH) ? sib(cur_q) : nxt_c;
		at_root_c   = (cnt_q == '0) && (cur_q == root_c);
		step_last_c = at_root_c || (nxt_c == root_c) ||
		              (({1'b0, cnt_q} + cntx_t'(1)) == cntx_t'(CAP));
	end

	always_comb begin
		sval_c  = '0;
		sflag_c = 1'b0;
		case (cmd_q)
			CMD_LEVEL:      sval_c  = field_t'(lvl(a_q));
			CMD_LEFT:       sval_c  = field_t'(lchild(a_q));
			CMD_RIGHT:      sval_c  = field_t'(rchild(a_q));
			CMD_PARENT:     sval_c  = field_t'(up(a_q));
			CMD_SIBLING:    sval_c  = field_t'(sib(a_q));
			CMD_ROOT:       sval_c  = field_t'(root_c);
			CMD_IN_SUBTREE: sflag_c = contains(a_q, b_q);
			CMD_ANCESTOR:   sval_c  = field_t'(meet(a_q, b_q));
			CMD_LEAF2NODE:  sval_c  = field_t'(a_q << 1);
			CMD_NODE2LEAF:  sval_c  = field_t'(a_q >> 1);
			CMD_IS_LEAF:    sflag_c = ~a_q[0];
			CMD_WIDTH:      sval_c  = (wx_c > wx_t'(FIELD_MAX)) ? FIELD_MAX : field_t'(w_c);
			default: begin
				sval_c  = '0;
				sflag_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_leaves_q <= N_LEAVES_RST;
			strobe_q   <= 1'b0;
			cur_q      <= '0;
			cnt_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				n_leaves_q <= cfg_wr_data;
			end
			strobe_q <= ctl.single | ctl.step;
			if (ctl.load) begin
				cur_q <= node_t'(node_a);
				cnt_q <= '0;
			end else if (ctl.step) begin
				cur_q <= nxt_c;
				cnt_q <= cnt_q + cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			a_q   <= node_t'(node_a);
			b_q   <= node_t'(node_b);
		end
		if (ctl.single) begin
			value_q <= sval_c;
			flag_q  <= sflag_c;
			empty_q <= 1'b0;
			last_q  <= 1'b1;
		end else if (ctl.step) begin
			value_q <= at_root_c ? '0 : field_t'(ent_c);
			flag_q  <= 1'b0;
			empty_q <= at_root_c;
			last_q  <= step_last_c;
		end
	end

	assign sts.path_cmd  = (command == CMD_DPATH) || (command == CMD_COPATH);
	assign sts.step_last = step_last_c;

	assign strobe    = strobe_q;
	assign value     = value_q;
	assign flag      = flag_q;
	assign empty_res = empty_q;
	assign last      = last_q;

endmodule

@@ hdl/array_tree_index_unit_core.sv @@
// Sequence: start is taken into the state register, then a single-result command's result is registered
// with strobe. A direct path or copath of m entries gives one entry per cycle, each registered with
// strobe, and keeps busy high while it walks; one parent step of the walker per cycle.
// A new command is taken only in idle, while busy is low, not while one is in progress.
// Results cannot be stalled. Reset (arst_n low) returns to idle and sets the leaf count to 1.
module array_tree_index_unit_core #(
	parameter int NODE_BITS = atiu_pkg::NODE_BITS_DEF,
	parameter int PATH_CAP  = atiu_pkg::PATH_CAP_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  atiu_pkg::cmd_t   command,
	input  atiu_pkg::field_t node_a,
	input  atiu_pkg::field_t node_b,
	input  logic             cfg_wr_en,
	input  atiu_pkg::field_t cfg_wr_data,
	output logic             strobe,
	output atiu_pkg::field_t value,
	output logic             flag,
	output logic             empty_res,
	output logic             last
);
	import atiu_pkg::*;

	dp_ctl_t ctl;
	dp_sts_t sts;

	atiu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	atiu_dp #(
		.NB     (NODE_BITS),
		.CAP_IN (PATH_CAP)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.command     (command),
		.node_a      (node_a),
		.node_b      (node_b),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.strobe      (strobe),
		.value       (value),
		.flag        (flag),
		.empty_res   (empty_res),
		.last        (last)
	);

endmodule
